### design/glyph_blend_blitter_top_defines.svh
// Assertion helpers for the blitter RTL.
`ifndef GLYPH_BLEND_BLITTER_TOP_DEFINES_SVH
`define GLYPH_BLEND_BLITTER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GBB_ASSERT_IMP(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("gbb assertion failed");

// Next-cycle implication, checked outside reset.
`define GBB_ASSERT_NXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("gbb assertion failed");

`endif

### design/gbb_pkg.sv
`timescale 1ns / 1ps
package gbb_pkg;

    // command codes
    localparam logic [1:0] KIND_SHEET_WR = 2'd0;
    localparam logic [1:0] KIND_FILL     = 2'd1;
    localparam logic [1:0] KIND_BLIT     = 2'd2;
    localparam logic [1:0] KIND_READ     = 2'd3;

    localparam logic [15:0] OPAQUE_BIT = 16'h8000;

    // linear sheet address before wrap: row < 127, column < 511, width <= 256
    localparam int LIN_W   = 15;
    // reciprocal of the sheet size scaled by 2^RECIP_SH
    localparam int RECIP_SH = 30;
    localparam int RECIP_W  = 25;
    localparam int QE_W     = 10;

    // (v * DIV31_MUL) >> DIV31_SH == v / 31 for v <= 976
    localparam logic [11:0] DIV31_MUL = 12'd2115;
    localparam int          DIV31_SH  = 16;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_DIV,
        ST_PIX,
        ST_MUL,
        ST_MOD,
        ST_SWR,
        ST_SRD,
        ST_BLEND,
        ST_BDIV,
        ST_RRD,
        ST_ROUT
    } state_t;

endpackage

### design/glyph_blend_blitter_top.sv
`timescale 1ns / 1ps
// glyph_blend_blitter_top: 2D engine over an RGB555 frame store and a byte glyph sheet.
// Input channel (in_valid / in_stall) carries one command per transaction:
//   sheet byte write, clipped rectangle fill, scaled alpha glyph blit, pixel read.
// Output channel (out_valid / out_stall) returns one transaction per pixel read only.
// Steps per command:
//   sheet write : address wrap by reciprocal multiply (MUL, MOD), then write (SWR).
//   fill        : one frame store write per clipped pixel.
//   blit        : step division, then per destination pixel the frame store
//                 read-modify-write: address (PIX), sheet address wrap (MUL, MOD),
//                 reads (SRD), blend (BLEND), write (BDIV); a pixel with alpha zero
//                 ends in BLEND, a clipped pixel or a clipped row in PIX.
//   pixel read  : frame store read (RRD), then ROUT loads the output register and
//                 raises out_valid; an off-frame position skips RRD and returns 0.
// Commands run one at a time; in_stall stays high until the current one ends.
// A read result waits in the output register; the block takes the next command
// meanwhile and only holds if a second read finishes before the first is taken.
// Reset: after rst_n releases the frame store is swept to 0x8000, one pixel a
// cycle, over all FRAME_WIDTH*FRAME_HEIGHT pixels (49152 by default) with in_stall high.
module glyph_blend_blitter_top #(
    parameter int FRAME_WIDTH  = 256,
    parameter int FRAME_HEIGHT = 192,
    parameter int SHEET_WIDTH  = 256,
    parameter int SHEET_ROWS   = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        kind,
    input  logic signed [9:0] pos_x,
    input  logic signed [9:0] pos_y,
    input  logic [7:0]        src_x,
    input  logic [5:0]        src_y,
    input  logic [7:0]        src_w,
    input  logic [5:0]        src_h,
    input  logic [8:0]        dst_w,
    input  logic [8:0]        dst_h,
    input  logic [15:0]       color,
    input  logic [7:0]        sheet_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [15:0]       pixel_value
);
    import gbb_pkg::*;

`include "glyph_blend_blitter_top_defines.svh"

    localparam int FRAME_SIZE = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int SHEET_SIZE = SHEET_WIDTH * SHEET_ROWS;
    localparam int FAW        = $clog2(FRAME_SIZE);
    localparam int SAW        = $clog2(SHEET_SIZE);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SH) / SHEET_SIZE);
    localparam logic signed [10:0] FW11 = 11'(FRAME_WIDTH);
    localparam logic signed [10:0] FH11 = 11'(FRAME_HEIGHT);

    // storage
    logic [15:0] frame_mem [FRAME_SIZE];
    logic [7:0]  sheet_mem [SHEET_SIZE];

    // memory ports
    logic           fr_we, fr_re, sh_we, sh_re;
    logic [FAW-1:0] fr_waddr, fr_raddr;
    logic [15:0]    fr_wdata, fr_q;
    logic [SAW-1:0] sh_addr;
    logic [7:0]     sh_q;

    state_t state_reg, state_next;

    // command
    logic [1:0]        kind_reg;
    logic signed [9:0] x_reg, y_reg;
    logic [7:0]        sx_reg;
    logic [5:0]        sy_reg;
    logic [8:0]        dw_reg, dh_reg;
    logic [15:0]       color_reg;
    logic [7:0]        byte_reg;

    // fill window
    logic [8:0] fl_reg, frt_reg, fb_reg, fc_reg, frw_reg;

    // step dividers
    logic [2:0] div_cnt_reg;
    logic [7:0] dcn_reg, dcq_reg, drn_reg, drq_reg;
    logic [8:0] dcr_reg, drr_reg;

    // blit walk
    logic [8:0] dx_reg, dy_reg, qc_reg, remc_reg, remr_reg;
    logic [6:0] qr_reg;

    logic [LIN_W-1:0] l_reg;
    logic [QE_W-1:0]  qe_reg;
    logic [SAW-1:0]   sa_reg;
    logic [FAW-1:0]   fa_reg, clr_cnt_reg;
    logic [9:0]       sum_r_reg, sum_g_reg, sum_b_reg;
    logic             rzero_reg;

    logic        out_valid_reg;
    logic [15:0] pixel_value_reg;

    // ---------------- combinational helpers ----------------
    logic accept;
    assign accept = in_valid && !in_stall;

    logic signed [10:0] px, py, xs, ys, xe, ye, fleft, fright, ftop, fbot;
    logic               row_out, col_out, fill_live, read_in;
    assign px = $signed({x_reg[9], x_reg}) + $signed({2'b00, dx_reg});
    assign py = $signed({y_reg[9], y_reg}) + $signed({2'b00, dy_reg});
    assign row_out = py[10] || (py >= FH11);
    assign col_out = px[10] || (px >= FW11);

    assign xs = {pos_x[9], pos_x};
    assign ys = {pos_y[9], pos_y};
    assign xe = xs + $signed({2'b00, dst_w});
    assign ye = ys + $signed({2'b00, dst_h});
    assign fleft  = xs[10] ? 11'sd0 : xs;
    assign ftop   = ys[10] ? 11'sd0 : ys;
    assign fright = (xe > FW11) ? FW11 : xe;
    assign fbot   = (ye > FH11) ? FH11 : ye;
    assign fill_live = (dst_w != 9'd0) && (dst_h != 9'd0)
                       && (fleft < fright) && (ftop < fbot);
    assign read_in = !xs[10] && (xs < FW11) && !ys[10] && (ys < FH11);

    // divider step
    logic [9:0] dc_t, dr_t;
    logic       dc_ge, dr_ge;
    assign dc_t  = {dcr_reg, dcn_reg[7]};
    assign dr_t  = {drr_reg, drn_reg[7]};
    assign dc_ge = dc_t >= {1'b0, dw_reg};
    assign dr_ge = dr_t >= {1'b0, dh_reg};

    // nearest-neighbour steps
    logic [9:0] csum, rsum;
    logic [8:0] qc_step, remc_step, remr_step;
    logic [6:0] qr_step;
    always_comb
    begin
        csum = {1'b0, remc_reg} + {1'b0, dcr_reg};
        qc_step = qc_reg + {1'b0, dcq_reg};
        remc_step = csum[8:0];
        if (csum >= {1'b0, dw_reg})
        begin
            remc_step = 9'(csum - {1'b0, dw_reg});
            qc_step   = qc_step + 9'd1;
        end
        rsum = {1'b0, remr_reg} + {1'b0, drr_reg};
        qr_step = qr_reg + drq_reg[6:0];
        remr_step = rsum[8:0];
        if (rsum >= {1'b0, dh_reg})
        begin
            remr_step = 9'(rsum - {1'b0, dh_reg});
            qr_step   = qr_step + 7'd1;
        end
    end

    // sheet linear address and its wrap
    logic [LIN_W-1:0] lin_blit, lin_wr;
    logic [6:0]       srow;
    logic [8:0]       scol;
    assign srow = {1'b0, sy_reg} + qr_reg;
    assign scol = {1'b0, sx_reg} + qc_reg;
    assign lin_blit = LIN_W'(srow) * LIN_W'(SHEET_WIDTH) + LIN_W'(scol);
    assign lin_wr   = LIN_W'(src_y) * LIN_W'(SHEET_WIDTH) + LIN_W'(src_x);

    logic [LIN_W+RECIP_W-1:0] recip_prod;
    logic [24:0]              qe_mul, mod_diff;
    logic [15:0]              mod_rem, mod_fix;
    assign recip_prod = (LIN_W+RECIP_W)'(l_reg) * (LIN_W+RECIP_W)'(RECIP);
    assign qe_mul   = 25'(qe_reg) * 25'(SHEET_SIZE);
    assign mod_diff = 25'(l_reg) - qe_mul;
    assign mod_rem  = mod_diff[15:0];
    assign mod_fix  = (mod_rem >= 16'(SHEET_SIZE)) ? 16'(mod_rem - 16'(SHEET_SIZE)) : mod_rem;

    // frame addresses
    logic [16:0] fa_blit, fa_read, fa_fill;
    assign fa_blit = 17'(py[7:0]) * 17'(FRAME_WIDTH) + 17'(px[7:0]);
    assign fa_read = 17'(ys[7:0]) * 17'(FRAME_WIDTH) + 17'(xs[7:0]);
    assign fa_fill = 17'(frw_reg[7:0]) * 17'(FRAME_WIDTH) + 17'(fc_reg[7:0]);

    // blend
    logic [4:0] alpha, alpha_inv;
    assign alpha     = sh_q[7:3];
    assign alpha_inv = 5'd31 - alpha;

    function automatic logic [9:0] mix(input logic [4:0] s, input logic [4:0] d,
                                       input logic [4:0] a, input logic [4:0] ai);
        mix = 10'(s * a) + 10'(d * ai) + 10'd15;
    endfunction

    function automatic logic [4:0] div31(input logic [9:0] v);
        logic [21:0] p;
        p = 22'(v) * 22'(DIV31_MUL);
        div31 = p[DIV31_SH+4:DIV31_SH];
    endfunction

    // walk advance
    logic adv_col, adv_row, col_last, row_last, blit_done;
    always_comb
    begin
        adv_col = 1'b0;
        adv_row = 1'b0;
        unique case (state_reg)
            ST_PIX:
            begin
                adv_row = row_out;
                adv_col = !row_out && col_out;
            end
            ST_BLEND: adv_col = (alpha == 5'd0);
            ST_BDIV:  adv_col = 1'b1;
            default:  ;
        endcase
    end
    assign col_last  = dx_reg == dw_reg - 9'd1;
    assign row_last  = dy_reg == dh_reg - 9'd1;
    assign blit_done = (adv_row || (adv_col && col_last)) && row_last;

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_cnt_reg == FAW'(FRAME_SIZE - 1)) state_next = ST_IDLE;
            ST_IDLE:
                if (accept)
                begin
                    unique case (kind)
                        KIND_SHEET_WR: state_next = ST_MUL;
                        KIND_FILL:     state_next = fill_live ? ST_FILL : ST_IDLE;
                        KIND_BLIT:     state_next = (dst_w == 9'd0 || dst_h == 9'd0)
                                                    ? ST_IDLE : ST_DIV;
                        KIND_READ:     state_next = read_in ? ST_RRD : ST_ROUT;
                    endcase
                end
            ST_FILL:
                if (fc_reg == frt_reg - 9'd1 && frw_reg == fb_reg - 9'd1)
                    state_next = ST_IDLE;
            ST_DIV:   if (div_cnt_reg == 3'd0) state_next = ST_PIX;
            ST_PIX:
                if (blit_done)                state_next = ST_IDLE;
                else if (!row_out && !col_out) state_next = ST_MUL;
            ST_MUL:   state_next = ST_MOD;
            ST_MOD:   state_next = (kind_reg == KIND_SHEET_WR) ? ST_SWR : ST_SRD;
            ST_SWR:   state_next = ST_IDLE;
            ST_SRD:   state_next = ST_BLEND;
            ST_BLEND:
                if (alpha == 5'd0) state_next = blit_done ? ST_IDLE : ST_PIX;
                else               state_next = ST_BDIV;
            ST_BDIV:  state_next = blit_done ? ST_IDLE : ST_PIX;
            ST_RRD:   state_next = ST_ROUT;
            ST_ROUT:  if (!out_valid_reg || !out_stall) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    // ---------------- outputs and memory controls ----------------
    always_comb
    begin
        in_stall = 1'b1;
        fr_we    = 1'b0;
        fr_re    = 1'b0;
        sh_we    = 1'b0;
        sh_re    = 1'b0;
        fr_waddr = fa_reg;
        fr_raddr = fa_reg;
        fr_wdata = color_reg | OPAQUE_BIT;
        sh_addr  = sa_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                fr_we    = 1'b1;
                fr_waddr = clr_cnt_reg;
                fr_wdata = OPAQUE_BIT;
            end
            ST_IDLE:  in_stall = 1'b0;
            ST_FILL:
            begin
                fr_we    = 1'b1;
                fr_waddr = fa_fill[FAW-1:0];
            end
            ST_SWR:   sh_we = 1'b1;
            ST_SRD:
            begin
                sh_re = 1'b1;
                fr_re = 1'b1;
            end
            ST_BDIV:
            begin
                fr_we    = 1'b1;
                fr_wdata = {1'b1, div31(sum_b_reg), div31(sum_g_reg), div31(sum_r_reg)};
            end
            ST_RRD:   fr_re = 1'b1;
            default:  ;
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign pixel_value = pixel_value_reg;

    // ---------------- memories ----------------
    always_ff @(posedge clk)
    begin
        if (fr_we)
            frame_mem[fr_waddr] <= fr_wdata;
        if (fr_re)
            fr_q <= frame_mem[fr_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sh_we)
            sheet_mem[sh_addr] <= byte_reg;
        if (sh_re)
            sh_q <= sheet_mem[sh_addr];
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + FAW'(1);
            if (state_reg == ST_ROUT && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    kind_reg  <= kind;
                    x_reg     <= pos_x;
                    y_reg     <= pos_y;
                    sx_reg    <= src_x;
                    sy_reg    <= src_y;
                    dw_reg    <= dst_w;
                    dh_reg    <= dst_h;
                    color_reg <= color;
                    byte_reg  <= sheet_byte;
                    l_reg     <= lin_wr;
                    fa_reg    <= fa_read[FAW-1:0];
                    rzero_reg <= !read_in;
                    fl_reg    <= fleft[8:0];
                    fc_reg    <= fleft[8:0];
                    frt_reg   <= fright[8:0];
                    frw_reg   <= ftop[8:0];
                    fb_reg    <= fbot[8:0];
                    div_cnt_reg <= 3'd7;
                    dcn_reg   <= src_w;
                    drn_reg   <= {2'b00, src_h};
                    dcr_reg   <= '0;
                    drr_reg   <= '0;
                    dcq_reg   <= '0;
                    drq_reg   <= '0;
                    dx_reg    <= '0;
                    dy_reg    <= '0;
                    qc_reg    <= '0;
                    qr_reg    <= '0;
                    remc_reg  <= '0;
                    remr_reg  <= '0;
                end
            ST_FILL:
                if (fc_reg == frt_reg - 9'd1)
                begin
                    fc_reg  <= fl_reg;
                    frw_reg <= frw_reg + 9'd1;
                end
                else
                    fc_reg <= fc_reg + 9'd1;
            ST_DIV:
            begin
                div_cnt_reg <= div_cnt_reg - 3'd1;
                dcn_reg <= {dcn_reg[6:0], 1'b0};
                drn_reg <= {drn_reg[6:0], 1'b0};
                dcr_reg <= dc_ge ? 9'(dc_t - {1'b0, dw_reg}) : dc_t[8:0];
                drr_reg <= dr_ge ? 9'(dr_t - {1'b0, dh_reg}) : dr_t[8:0];
                dcq_reg <= {dcq_reg[6:0], dc_ge};
                drq_reg <= {drq_reg[6:0], dr_ge};
            end
            ST_PIX:
            begin
                l_reg  <= lin_blit;
                fa_reg <= fa_blit[FAW-1:0];
            end
            ST_MUL:   qe_reg <= recip_prod[RECIP_SH+QE_W-1:RECIP_SH];
            ST_MOD:   sa_reg <= mod_fix[SAW-1:0];
            ST_BLEND:
            begin
                sum_r_reg <= mix(color_reg[4:0],   fr_q[4:0],   alpha, alpha_inv);
                sum_g_reg <= mix(color_reg[9:5],   fr_q[9:5],   alpha, alpha_inv);
                sum_b_reg <= mix(color_reg[14:10], fr_q[14:10], alpha, alpha_inv);
            end
            ST_ROUT:
                if (!out_valid_reg || !out_stall)
                    pixel_value_reg <= rzero_reg ? 16'd0 : fr_q;
            default: ;
        endcase

        // walk counters, shared by the three pixel-ending states
        if (adv_row || (adv_col && col_last))
        begin
            dx_reg   <= '0;
            qc_reg   <= '0;
            remc_reg <= '0;
            dy_reg   <= dy_reg + 9'd1;
            qr_reg   <= qr_step;
            remr_reg <= remr_step;
        end
        else if (adv_col)
        begin
            dx_reg   <= dx_reg + 9'd1;
            qc_reg   <= qc_step;
            remc_reg <= remc_step;
        end
    end

    // ---------------- assertions ----------------
    `GBB_ASSERT_IMP(a_step_rem_bound, state_reg == ST_PIX,
                    (remc_reg < dw_reg) && (remr_reg < dh_reg))
    `GBB_ASSERT_IMP(a_out_rise_from_read, $rose(out_valid_reg),
                    $past(state_reg) == ST_ROUT)
    `GBB_ASSERT_IMP(a_one_frame_access, fr_we, !fr_re && !sh_we)
    `GBB_ASSERT_NXT(a_clear_done_idle,
                    state_reg == ST_CLEAR && clr_cnt_reg == FAW'(FRAME_SIZE - 1),
                    state_reg == ST_IDLE)

endmodule

### tb/glyph_blend_blitter_checker.sv
`timescale 1ns / 1ps
// Watches both channels, mirrors frame store and glyph sheet, checks pixel reads.
module glyph_blend_blitter_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [1:0]        kind,
    input  logic signed [9:0] pos_x,
    input  logic signed [9:0] pos_y,
    input  logic [7:0]        src_x,
    input  logic [5:0]        src_y,
    input  logic [7:0]        src_w,
    input  logic [5:0]        src_h,
    input  logic [8:0]        dst_w,
    input  logic [8:0]        dst_h,
    input  logic [15:0]       color,
    input  logic [7:0]        sheet_byte,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [15:0]       pixel_value,
    output int                n_fail,
    output int                n_pending
);
    import gbb_pkg::*;

    localparam int FW = 256;
    localparam int FH = 192;
    localparam int SW = 256;
    localparam int SHEET_SIZE = 256 * 64;

    logic [15:0] frame_mirror [FW*FH];
    logic [7:0]  sheet_mirror [SHEET_SIZE];
    logic [15:0] read_q [$];
    logic [15:0] want;

    initial
    begin
        for (int i = 0; i < FW*FH; i++)
            frame_mirror[i] = OPAQUE_BIT;
        for (int i = 0; i < SHEET_SIZE; i++)
            sheet_mirror[i] = '0;
        n_fail = 0;
        n_pending = 0;
    end

    function automatic int mix_chan(int s, int d, int a);
        return (s * a + d * (31 - a) + 15) / 31;
    endfunction

    function automatic logic [15:0] mix_pixel(logic [15:0] d, logic [15:0] s, int a);
        int r, g, b;
        r = mix_chan(int'(s[4:0]), int'(d[4:0]), a);
        g = mix_chan(int'(s[9:5]), int'(d[9:5]), a);
        b = mix_chan(int'(s[14:10]), int'(d[14:10]), a);
        return {1'b1, b[4:0], g[4:0], r[4:0]};
    endfunction

    task automatic report(string what, logic [15:0] expected, logic [15:0] got);
        $display("%0t: mismatch in %s: expected %h, got %h", $realtime, what, expected, got);
        n_fail++;
    endtask

    task automatic apply_cmd();
        int x, y, px, py, row, col, adr, a;
        x = int'(pos_x);
        y = int'(pos_y);
        case (kind)
            KIND_SHEET_WR:
                sheet_mirror[(int'(src_y) * SW + int'(src_x)) % SHEET_SIZE] = sheet_byte;
            KIND_FILL:
                if (dst_w != 0 && dst_h != 0)
                begin
                    for (int r = (y < 0 ? 0 : y); r < y + int'(dst_h) && r < FH; r++)
                        for (int c = (x < 0 ? 0 : x); c < x + int'(dst_w) && c < FW; c++)
                            frame_mirror[r*FW + c] = color | OPAQUE_BIT;
                end
            KIND_BLIT:
                if (dst_w != 0 && dst_h != 0)
                begin
                    for (int dy = 0; dy < int'(dst_h); dy++)
                    begin
                        py = y + dy;
                        if (py < 0 || py >= FH)
                            continue;
                        row = int'(src_y) + dy * int'(src_h) / int'(dst_h);
                        for (int dx = 0; dx < int'(dst_w); dx++)
                        begin
                            px = x + dx;
                            if (px < 0 || px >= FW)
                                continue;
                            col = int'(src_x) + dx * int'(src_w) / int'(dst_w);
                            adr = (row * SW + col) % SHEET_SIZE;
                            a = int'(sheet_mirror[adr] >> 3);
                            if (a != 0)
                                frame_mirror[py*FW + px] =
                                    mix_pixel(frame_mirror[py*FW + px], color, a);
                        end
                    end
                end
            default:
                if (x < 0 || x >= FW || y < 0 || y >= FH)
                    read_q.push_back(16'h0000);
                else
                    read_q.push_back(frame_mirror[y*FW + x]);
        endcase
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                apply_cmd();
            if (out_valid && !out_stall)
            begin
                if (read_q.size() == 0)
                    report("pixel_value (unexpected transaction)", 16'h0000, pixel_value);
                else
                begin
                    want = read_q.pop_front();
                    if (want !== pixel_value)
                        report("pixel_value", want, pixel_value);
                end
            end
            n_pending = read_q.size();
        end
    end
endmodule

### tb/tb_glyph_blend_blitter_top.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the glyph blitter; checking lives in the checker.
module tb_glyph_blend_blitter_top;
    import gbb_pkg::*;

    localparam int FW = 256;
    localparam int FH = 192;
    localparam int SHEET_SIZE = 256 * 64;
    localparam int N_ITEMS = 1750;
    localparam int HOLD_CYCLES = 3000;

    typedef struct {
        logic [1:0]        kind;
        logic signed [9:0] pos_x;
        logic signed [9:0] pos_y;
        logic [7:0]        src_x;
        logic [5:0]        src_y;
        logic [7:0]        src_w;
        logic [5:0]        src_h;
        logic [8:0]        dst_w;
        logic [8:0]        dst_h;
        logic [15:0]       color;
        logic [7:0]        sheet_byte;
    } gbb_cmd_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        kind;
    logic signed [9:0] pos_x;
    logic signed [9:0] pos_y;
    logic [7:0]        src_x;
    logic [5:0]        src_y;
    logic [7:0]        src_w;
    logic [5:0]        src_h;
    logic [8:0]        dst_w;
    logic [8:0]        dst_h;
    logic [15:0]       color;
    logic [7:0]        sheet_byte;
    logic              out_valid;
    logic              out_stall;
    logic [15:0]       pixel_value;

    int n_fail;
    int n_pending;

    // idling percentages of the current phase
    int gap_pct;
    int stall_pct;
    // bumped (nonblocking) to ask the receiver for one long hold-off
    int hold_seq;
    int sent;

    // sheet texels written so far; a blit never samples an unwritten one
    bit texel_known [SHEET_SIZE];

    glyph_blend_blitter_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .pos_x(pos_x), .pos_y(pos_y),
        .src_x(src_x), .src_y(src_y), .src_w(src_w), .src_h(src_h),
        .dst_w(dst_w), .dst_h(dst_h), .color(color), .sheet_byte(sheet_byte),
        .out_valid(out_valid), .out_stall(out_stall), .pixel_value(pixel_value)
    );

    glyph_blend_blitter_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .pos_x(pos_x), .pos_y(pos_y),
        .src_x(src_x), .src_y(src_y), .src_w(src_w), .src_h(src_h),
        .dst_w(dst_w), .dst_h(dst_h), .color(color), .sheet_byte(sheet_byte),
        .out_valid(out_valid), .out_stall(out_stall), .pixel_value(pixel_value),
        .n_fail(n_fail), .n_pending(n_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Limit: time for the reset sweep plus worst-case commands.
    initial
    begin
        #200_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Receiver: random stalls per phase; a hold request forces a long stretch
    // of stall, counted here, so reads back up and the block stalls its input.
    initial
    begin
        int seen;
        seen = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seq != seen)
            begin
                seen = hold_seq;
                for (int i = 0; i < HOLD_CYCLES; i++)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // One command transaction, then an optional sender gap.
    task automatic send(input gbb_cmd_t c);
        kind       <= c.kind;
        pos_x      <= c.pos_x;
        pos_y      <= c.pos_y;
        src_x      <= c.src_x;
        src_y      <= c.src_y;
        src_w      <= c.src_w;
        src_h      <= c.src_h;
        dst_w      <= c.dst_w;
        dst_h      <= c.dst_h;
        color      <= c.color;
        sheet_byte <= c.sheet_byte;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
        if ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < gap_pct);
        end
    endtask

    function automatic gbb_cmd_t blank_cmd(logic [1:0] k);
        gbb_cmd_t c;
        c.kind = k;
        c.pos_x = 10'($urandom);
        c.pos_y = 10'($urandom);
        c.src_x = 8'($urandom);
        c.src_y = 6'($urandom);
        c.src_w = 8'($urandom);
        c.src_h = 6'($urandom);
        c.dst_w = 9'($urandom);
        c.dst_h = 9'($urandom);
        c.color = 16'($urandom);
        c.sheet_byte = 8'($urandom);
        return c;
    endfunction

    task automatic write_texel(int adr, logic [7:0] val);
        gbb_cmd_t c;
        c = blank_cmd(KIND_SHEET_WR);
        c.src_x = 8'(adr % 256);
        c.src_y = 6'(adr / 256);
        c.sheet_byte = val;
        texel_known[adr] = 1'b1;
        send(c);
    endtask

    // random texel, alpha zero now and then
    function automatic logic [7:0] rand_texel();
        logic [7:0] v;
        v = 8'($urandom);
        if ($urandom_range(4) == 0)
            v[7:3] = 5'd0;
        return v;
    endfunction

    // A blit preceded by writes of every texel it samples that is still unknown.
    task automatic blit(gbb_cmd_t c);
        int px, py, row, col, adr;
        c.kind = KIND_BLIT;
        if (c.dst_w != 0 && c.dst_h != 0)
        begin
            for (int dy = 0; dy < int'(c.dst_h); dy++)
            begin
                py = int'(c.pos_y) + dy;
                if (py < 0 || py >= FH)
                    continue;
                row = int'(c.src_y) + dy * int'(c.src_h) / int'(c.dst_h);
                for (int dx = 0; dx < int'(c.dst_w); dx++)
                begin
                    px = int'(c.pos_x) + dx;
                    if (px < 0 || px >= FW)
                        continue;
                    col = int'(c.src_x) + dx * int'(c.src_w) / int'(c.dst_w);
                    adr = (row * 256 + col) % SHEET_SIZE;
                    if (!texel_known[adr])
                        write_texel(adr, rand_texel());
                end
            end
        end
        send(c);
    endtask

    task automatic cmd_at(logic [1:0] k, int x, int y, int w, int h, logic [15:0] col);
        gbb_cmd_t c;
        c = blank_cmd(k);
        c.pos_x = 10'(x);
        c.pos_y = 10'(y);
        c.dst_w = 9'(w);
        c.dst_h = 9'(h);
        c.color = col;
        if (k == KIND_BLIT)
            blit(c);
        else
            send(c);
    endtask

    task automatic rand_item();
        gbb_cmd_t c;
        int sel;
        sel = $urandom_range(99);
        c = blank_cmd(KIND_READ);
        // most drawing and reading lands in a small hot corner
        if ($urandom_range(9) < 8)
        begin
            c.pos_x = 10'(int'($urandom_range(40)) - 8);
            c.pos_y = 10'(int'($urandom_range(40)) - 8);
        end
        if (sel < 12)
        begin
            c.kind = KIND_SHEET_WR;
            c.sheet_byte = rand_texel();
            texel_known[int'(c.src_y) * 256 + int'(c.src_x)] = 1'b1;
            send(c);
        end
        else if (sel < 35)
        begin
            c.kind = KIND_FILL;
            if ($urandom_range(19) != 0)
            begin
                c.dst_w = 9'($urandom_range(24));
                c.dst_h = 9'($urandom_range(24));
            end
            send(c);
        end
        else if (sel < 65)
        begin
            // glyph-sized blits, usually from a compact sheet region
            c.dst_w = 9'($urandom_range(12));
            c.dst_h = 9'($urandom_range(12));
            if ($urandom_range(3) != 0)
            begin
                c.src_x = 8'($urandom_range(31));
                c.src_y = 6'($urandom_range(7));
                c.src_w = 8'($urandom_range(8));
                c.src_h = 6'($urandom_range(8));
            end
            blit(c);
        end
        else
            send(c);
    endtask

    initial
    begin
        gbb_cmd_t c;
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = KIND_SHEET_WR;
        pos_x = '0;
        pos_y = '0;
        src_x = '0;
        src_y = '0;
        src_w = '0;
        src_h = '0;
        dst_w = '0;
        dst_h = '0;
        color = '0;
        sheet_byte = '0;
        gap_pct = 0;
        stall_pct = 0;
        hold_seq = 0;
        sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: corners, clipping, zero sizes, sheet wrap, alpha zero
        cmd_at(KIND_READ, 0, 0, 0, 0, 0);               // cleared black
        write_texel(0, 8'hFF);
        write_texel(SHEET_SIZE - 1, 8'h07);             // alpha zero texel
        write_texel(1, 8'h08);                          // weakest alpha
        cmd_at(KIND_FILL, 0, 0, FW, FH, 16'hFFFF);      // whole frame
        cmd_at(KIND_READ, FW - 1, FH - 1, 0, 0, 0);
        cmd_at(KIND_FILL, -5, -5, 10, 10, 16'h7C1F);    // clipped top-left
        cmd_at(KIND_FILL, 250, 186, 511, 511, 16'h03E0);// clipped bottom-right
        cmd_at(KIND_FILL, 20, 20, 0, 9, 16'h1234);      // zero width
        cmd_at(KIND_FILL, 20, 20, 9, 0, 16'h1234);      // zero height
        cmd_at(KIND_FILL, 511, 511, 4, 4, 16'h0000);    // fully off frame
        cmd_at(KIND_READ, 0, 0, 0, 0, 0);
        cmd_at(KIND_READ, FW, 0, 0, 0, 0);              // off frame reads zero
        cmd_at(KIND_READ, -1, -1, 0, 0, 0);
        cmd_at(KIND_READ, -512, 511, 0, 0, 0);
        c = blank_cmd(KIND_BLIT);
        c.pos_x = 2; c.pos_y = 2; c.src_x = 0; c.src_y = 0;
        c.src_w = 0; c.src_h = 0; c.dst_w = 4; c.dst_h = 3; c.color = 16'h7FFF;
        blit(c);                                        // zero source size
        c.src_x = 8'hFF; c.src_y = 6'h3F; c.src_w = 8'hFF; c.src_h = 6'h3F;
        c.dst_w = 5; c.dst_h = 5; c.pos_x = -2; c.pos_y = 189;
        blit(c);                                        // sheet wrap, clipped
        c.dst_w = 0;
        blit(c);                                        // zero destination
        c.pos_x = -512; c.pos_y = -512; c.dst_w = 511; c.dst_h = 511;
        blit(c);                                        // huge, fully clipped
        cmd_at(KIND_READ, 3, 2, 0, 0, 0);
        cmd_at(KIND_READ, 0, 190, 0, 0, 0);

        // random phases: none, sender gaps, receiver stalls, both
        for (int ph = 0; ph < 4; ph++)
        begin
            gap_pct   = (ph == 1) ? 51 : (ph == 3) ? 17 : 0;
            stall_pct = (ph == 2) ? 51 : (ph == 3) ? 17 : 0;
            if (ph == 0)
            begin
                // long hold-off while reads keep coming
                hold_seq <= hold_seq + 1;
                for (int i = 0; i < 12; i++)
                    cmd_at(KIND_READ, $urandom_range(40), $urandom_range(40), 0, 0, 0);
            end
            while (sent < (N_ITEMS * (ph + 1)) / 4)
                rand_item();
        end

        in_valid <= 1'b0;
        gap_pct = 0;
        stall_pct = 0;
        while (n_pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (n_fail == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

### files.f
+incdir+design
design/gbb_pkg.sv
design/glyph_blend_blitter_top.sv
tb/glyph_blend_blitter_checker.sv
tb/tb_glyph_blend_blitter_top.sv
